// ===== rtl/slt_pkg.sv =====
// Shared types, character codes and helper functions for the serial line tokenizer.
// No dependencies; the top level, the push controller and the testbench import this package.
`default_nettype none

package slt_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int LINE_BYTES_DEF = 64;
    localparam int MAX_TOKENS_DEF = 8;

    // Shortest line that records a final token end.
    localparam int MIN_LINE_BYTES = 2;

    // Operation codes of the input word.
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_QUERY = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Character codes that steer tokenizing.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Status of one push, passed from the push controller to the top level.
    typedef struct packed {
        logic line_we;
        logic end_we;
        logic line_done;
        logic overflow;
    } push_ctl_t;

    // Whitespace is stored as zero and closes a token.
    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
               (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
    endfunction

    // Characters that terminate the line.
    function automatic logic is_line_end(input logic [7:0] ch);
        return (ch == CH_LF) || (ch == CH_CR) || (ch == CH_NUL);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/serial_line_tokenizer_unit.sv =====
// Serial line tokenizer with line store and token end table.
// Top level; uses slt_pkg, slt_line_mem, slt_end_mem and slt_push_ctrl.
//
// Usage:
//   The s_ channel carries one word per handshake: op selects a push of
//   char_in, a token query by token_index, or a read of byte_address.
//   Every accepted word produces exactly one result word on the m_ channel;
//   fields that do not belong to the word's op are zero.
//   On its way from acceptance to m_valid a word first passes the memory
//   read stage, which reads the line store or the end table (both synchronous
//   memories), and then the output register, which holds the formed result.
//   Throughput is one word per cycle. Each word makes at most one access to
//   each memory, and a write at the accepting edge is seen by any later read.
//   When the receiver stalls, one word waits in the output register and one
//   in the memory read stage; s_ready falls only when both are occupied.
//   Reset (aresetn low, synchronous) empties the line, clears the pending
//   clear and drops both pipeline stages. Store contents are not cleared.
`default_nettype none

module serial_line_tokenizer_unit
    import slt_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_op,
    input  wire logic [7:0] s_char_in,
    input  wire logic [7:0] s_token_index,
    input  wire logic [7:0] s_byte_address,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_line_done,
    output logic            m_input_overflow,
    output logic            m_token_missing,
    output logic [7:0]      m_token_offset,
    output logic [7:0]      m_token_length,
    output logic [7:0]      m_byte_value
);

    localparam int LINE_AW = $clog2(LINE_BYTES);
    localparam int END_AW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int ECNT_W  = $clog2(MAX_TOKENS + 1);

    op_t               in_op;
    logic              accept;
    logic              push_en;
    logic              query_miss;
    logic              read_oor;
    logic              out_free;

    push_ctl_t         push_status;
    logic [LINE_AW-1:0] line_wr_addr;
    logic [7:0]         line_wr_data;
    logic [END_AW-1:0]  end_wr_addr;
    logic [7:0]         end_wr_data;
    logic [ECNT_W-1:0]  end_count;
    logic [7:0]         line_rd_data;
    logic [END_AW-1:0]  end_hi_addr;
    logic [7:0]         end_hi_data;
    logic [7:0]         end_lo_data;

    // Memory read stage.
    logic v1_reg;
    op_t  op1_reg;
    logic done1_reg, ovf1_reg, miss1_reg, zero1_reg, oor1_reg;

    // Output register.
    logic       m_valid_reg;
    logic       done_reg, ovf_reg, miss_reg;
    logic [7:0] offs_reg, len_reg, val_reg;
    logic       done_next, ovf_next, miss_next;
    logic [7:0] offs_next, len_next, val_next;

    // Handshake: the read stage advances whenever the output register is free.
    assign in_op    = op_t'(s_op);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !v1_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign push_en  = accept && (in_op == OP_PUSH);

    // Query and read range checks against the current line.
    assign query_miss = (s_token_index >= 8'(end_count)) ||
                        (s_token_index >= 8'(MAX_TOKENS));
    assign read_oor   = s_byte_address >= 8'(LINE_BYTES);
    assign end_hi_addr = s_token_index[END_AW-1:0];

    slt_push_ctrl #(
        .LINE_BYTES (LINE_BYTES),
        .MAX_TOKENS (MAX_TOKENS),
        .LINE_AW    (LINE_AW),
        .END_AW     (END_AW),
        .ECNT_W     (ECNT_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_en      (push_en),
        .char_in      (s_char_in),
        .status       (push_status),
        .line_wr_addr (line_wr_addr),
        .line_wr_data (line_wr_data),
        .end_wr_addr  (end_wr_addr),
        .end_wr_data  (end_wr_data),
        .end_count    (end_count)
    );

    slt_line_mem #(
        .LINE_BYTES (LINE_BYTES),
        .LINE_AW    (LINE_AW)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (push_status.line_we),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data),
        .rd_en   (accept && (in_op == OP_READ) && !read_oor),
        .rd_addr (s_byte_address[LINE_AW-1:0]),
        .rd_data (line_rd_data)
    );

    slt_end_mem #(
        .MAX_TOKENS (MAX_TOKENS),
        .END_AW     (END_AW)
    ) u_end_mem (
        .aclk       (aclk),
        .wr_en      (push_status.end_we),
        .wr_addr    (end_wr_addr),
        .wr_data    (end_wr_data),
        .rd_en      (accept && (in_op == OP_QUERY) && !query_miss),
        .rd_hi_addr (end_hi_addr),
        .rd_lo_addr (end_hi_addr - END_AW'(1)),
        .rd_hi_data (end_hi_data),
        .rd_lo_data (end_lo_data)
    );

    // Read stage control; payload flags are captured with each accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (accept) begin
            v1_reg <= 1'b1;
        end else if (out_free) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op1_reg   <= in_op;
            done1_reg <= push_status.line_done;
            ovf1_reg  <= push_status.overflow;
            miss1_reg <= query_miss;
            zero1_reg <= (s_token_index == 8'd0);
            oor1_reg  <= read_oor;
        end
    end

    // Form the result from the memory data.
    always_comb begin
        done_next = 1'b0;
        ovf_next  = 1'b0;
        miss_next = 1'b0;
        offs_next = 8'd0;
        len_next  = 8'd0;
        val_next  = 8'd0;
        unique case (op1_reg)
            OP_PUSH: begin
                done_next = done1_reg;
                ovf_next  = ovf1_reg;
            end
            OP_QUERY: begin
                if (miss1_reg) begin
                    miss_next = 1'b1;
                end else begin
                    offs_next = zero1_reg ? 8'd0 : end_lo_data;
                    len_next  = end_hi_data - offs_next - 8'd1;
                end
            end
            OP_READ: begin
                val_next = oor1_reg ? 8'd0 : line_rd_data;
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && v1_reg) begin
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            miss_reg <= miss_next;
            offs_reg <= offs_next;
            len_reg  <= len_next;
            val_reg  <= val_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_line_done      = done_reg;
    assign m_input_overflow = ovf_reg;
    assign m_token_missing  = miss_reg;
    assign m_token_offset   = offs_reg;
    assign m_token_length   = len_reg;
    assign m_byte_value     = val_reg;

    // Every accepted word occupies the read stage on the next cycle.
    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> v1_reg)
        else $error("accepted word lost before the read stage");

    // With both stages full and the receiver stalled, no word may enter.
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("word accepted into a full pipeline");

    // A missing token carries no position.
    a_missing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && miss_reg) |-> (offs_reg == 8'd0) && (len_reg == 8'd0))
        else $error("missing token reported with a position");

endmodule

`default_nettype wire

// ===== rtl/slt_line_mem.sv =====
// Line store: one write port and one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module slt_line_mem #(
    parameter int LINE_BYTES = 64,
    parameter int LINE_AW    = $clog2(LINE_BYTES)
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [LINE_AW-1:0] wr_addr,
    input  wire logic [7:0]         wr_data,
    input  wire logic               rd_en,
    input  wire logic [LINE_AW-1:0] rd_addr,
    output logic      [7:0]         rd_data
);

    logic [7:0] mem [LINE_BYTES];

    // Write the pushed byte.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slt_end_mem.sv =====
// Token end table: one write port and two registered read ports.
// The two reads fetch the end of a token and the end of the token before it.
`default_nettype none

module slt_end_mem #(
    parameter int MAX_TOKENS = 8,
    parameter int END_AW     = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [END_AW-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [END_AW-1:0] rd_hi_addr,
    input  wire logic [END_AW-1:0] rd_lo_addr,
    output logic      [7:0]        rd_hi_data,
    output logic      [7:0]        rd_lo_data
);

    logic [7:0] mem [MAX_TOKENS];

    // Record a token end.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Both reads are registered together.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_hi_data <= mem[rd_hi_addr];
            rd_lo_data <= mem[rd_lo_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slt_push_ctrl.sv =====
// Push controller: fill count, token end count and the pending clear.
// Decides where each pushed byte and each token end is written. Uses slt_pkg.
`default_nettype none

module slt_push_ctrl
    import slt_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int MAX_TOKENS = MAX_TOKENS_DEF,
    parameter int LINE_AW    = $clog2(LINE_BYTES),
    parameter int END_AW     = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1,
    parameter int ECNT_W     = $clog2(MAX_TOKENS + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_en,
    input  wire logic [7:0]         char_in,
    output push_ctl_t               status,
    output logic      [LINE_AW-1:0] line_wr_addr,
    output logic      [7:0]         line_wr_data,
    output logic      [END_AW-1:0]  end_wr_addr,
    output logic      [7:0]         end_wr_data,
    output logic      [ECNT_W-1:0]  end_count
);

    localparam int FILL_W = $clog2(LINE_BYTES + 1);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [ECNT_W-1:0] end_reg, end_next;
    logic              clear_reg, clear_next;

    logic [FILL_W-1:0] base_fill;
    logic [FILL_W-1:0] new_fill;
    logic [ECNT_W-1:0] base_end;
    logic              record;

    // A pending clear empties the line before the byte is taken.
    assign base_fill = clear_reg ? '0 : fill_reg;
    assign base_end  = clear_reg ? '0 : end_reg;
    assign new_fill  = base_fill + FILL_W'(1);

    // Decide the effect of one push.
    always_comb begin
        fill_next    = fill_reg;
        end_next     = end_reg;
        clear_next   = clear_reg;
        status       = '0;
        record       = 1'b0;
        line_wr_addr = base_fill[LINE_AW-1:0];
        line_wr_data = is_blank(char_in) ? 8'd0 : char_in;
        end_wr_addr  = base_end[END_AW-1:0];
        end_wr_data  = 8'(new_fill);
        if (push_en) begin
            fill_next  = base_fill;
            end_next   = base_end;
            clear_next = 1'b0;
            if (base_fill >= FILL_W'(LINE_BYTES)) begin
                // Store full: drop the byte and start over.
                fill_next       = '0;
                end_next        = '0;
                status.overflow = 1'b1;
            end else begin
                status.line_we = 1'b1;
                fill_next      = new_fill;
                if (is_line_end(char_in)) begin
                    clear_next = 1'b1;
                    if (new_fill >= FILL_W'(MIN_LINE_BYTES)) begin
                        record           = 1'b1;
                        status.line_done = 1'b1;
                    end
                end else if (is_blank(char_in)) begin
                    record = 1'b1;
                end
                // Ends beyond the table are ignored.
                if (record && (base_end < ECNT_W'(MAX_TOKENS))) begin
                    status.end_we = 1'b1;
                    end_next      = base_end + ECNT_W'(1);
                end
            end
        end
    end

    // Line state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            end_reg   <= '0;
            clear_reg <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            end_reg   <= end_next;
            clear_reg <= clear_next;
        end
    end

    assign end_count = end_reg;

    // An overflow always leaves an empty line behind.
    a_overflow_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_en && status.overflow) |=> (fill_reg == '0) && (end_reg == '0))
        else $error("overflow did not empty the line");

    // The end count never passes the table size.
    a_end_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        end_reg <= ECNT_W'(MAX_TOKENS))
        else $error("end count beyond table size");

    // The fill count never passes the store size.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(LINE_BYTES))
        else $error("fill count beyond store size");

endmodule

`default_nettype wire

// ===== tb/sv/serial_line_tokenizer_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for serial_line_tokenizer_unit: directed table, then random lines.
// Depends on slt_pkg and the tokenizer RTL; every result word is checked against a predictor or a table value.

module serial_line_tokenizer_unit_tb;
    import slt_pkg::*;

    localparam int LINE_BYTES = LINE_BYTES_DEF;
    localparam int MAX_TOKENS = MAX_TOKENS_DEF;
    localparam int RANDOM_WORDS = 750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLDOFF_AFTER = 300;
    localparam int HOLDOFF_CYCLES = 80;
    localparam logic [7:0] CH_FIRST_PRINT = 8'h21;
    localparam logic [7:0] CH_LAST_PRINT = 8'h7E;

    // One result word, field by field.
    typedef struct packed {
        logic       line_done;
        logic       input_overflow;
        logic       token_missing;
        logic [7:0] token_offset;
        logic [7:0] token_length;
        logic [7:0] byte_value;
    } result_t;

    // One row of the directed table; reps repeats the same word.
    typedef struct {
        op_t         op;
        logic [7:0]  ch;
        logic [7:0]  idx;
        logic [7:0]  addr;
        int unsigned reps;
        bit          typed;
        result_t     want;
    } step_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_op = OP_NONE;
    logic [7:0] s_char_in = 8'h00;
    logic [7:0] s_token_index = 8'h00;
    logic [7:0] s_byte_address = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_line_done;
    logic       m_input_overflow;
    logic       m_token_missing;
    logic [7:0] m_token_offset;
    logic [7:0] m_token_length;
    logic [7:0] m_byte_value;

    // Predicted copy of the line store and token end table.
    logic [7:0]  line_copy [LINE_BYTES];
    logic [7:0]  end_pos [MAX_TOKENS];
    int unsigned fill_level = 0;
    int unsigned end_total = 0;
    bit          clear_due = 1'b0;
    int unsigned written_top = 0;

    result_t     pending_results [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned words_sent = 0;
    int unsigned burst_left = 0;
    int unsigned cycles = 0;

    serial_line_tokenizer_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_char_in        (s_char_in),
        .s_token_index    (s_token_index),
        .s_byte_address   (s_byte_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_line_done      (m_line_done),
        .m_input_overflow (m_input_overflow),
        .m_token_missing  (m_token_missing),
        .m_token_offset   (m_token_offset),
        .m_token_length   (m_token_length),
        .m_byte_value     (m_byte_value)
    );

    always #10 aclk = ~aclk;

    // Applies one accepted word to the predicted line state and returns its result.
    function automatic result_t tokenize_step(input op_t op, input logic [7:0] ch,
                                              input logic [7:0] idx, input logic [7:0] addr);
        result_t     r;
        logic [7:0]  start;
        bit          blank;
        bit          line_end;
        r = '0;
        blank = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        line_end = (ch == CH_LF) || (ch == CH_CR) || (ch == CH_NUL);
        case (op)
            OP_PUSH: begin
                // A finished line is emptied by the next pushed character.
                if (clear_due) begin
                    fill_level = 0;
                    end_total = 0;
                    clear_due = 1'b0;
                end
                if (fill_level >= LINE_BYTES) begin
                    fill_level = 0;
                    end_total = 0;
                    r.input_overflow = 1'b1;
                end else begin
                    line_copy[fill_level] = blank ? 8'h00 : ch;
                    fill_level++;
                    if (fill_level > written_top)
                        written_top = fill_level;
                    if (line_end && fill_level >= MIN_LINE_BYTES)
                        r.line_done = 1'b1;
                    // Token ends past the table size are dropped.
                    if ((r.line_done || (!line_end && blank)) && end_total < MAX_TOKENS) begin
                        end_pos[end_total] = fill_level[7:0];
                        end_total++;
                    end
                    if (line_end)
                        clear_due = 1'b1;
                end
            end
            OP_QUERY: begin
                if (idx >= end_total || idx >= MAX_TOKENS) begin
                    r.token_missing = 1'b1;
                end else begin
                    start = (idx > 0) ? end_pos[idx - 1] : 8'h00;
                    r.token_offset = start;
                    r.token_length = end_pos[idx] - start - 8'd1;
                end
            end
            OP_READ: begin
                if (addr < LINE_BYTES)
                    r.byte_value = line_copy[addr];
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic result_t flag_result(input bit done, input bit ovf, input bit miss);
        result_t r;
        r = '0;
        r.line_done = done;
        r.input_overflow = ovf;
        r.token_missing = miss;
        return r;
    endfunction

    function automatic step_t row(input op_t op, input logic [7:0] ch, input logic [7:0] idx,
                                  input logic [7:0] addr, input int unsigned reps,
                                  input bit typed, input result_t want);
        step_t s;
        s.op = op;
        s.ch = ch;
        s.idx = idx;
        s.addr = addr;
        s.reps = reps;
        s.typed = typed;
        s.want = want;
        return s;
    endfunction

    // Offers one word in bursts with random gaps, then records its expected result.
    task automatic send_word(input op_t op, input logic [7:0] ch, input logic [7:0] idx,
                             input logic [7:0] addr, input bit typed, input result_t want);
        result_t predicted;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_op <= op;
        s_char_in <= ch;
        s_token_index <= idx;
        s_byte_address <= addr;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = tokenize_step(op, ch, idx, addr);
        pending_results.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    task automatic push_char(input logic [7:0] ch);
        send_word(OP_PUSH, ch, 8'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    // Random query or read; reads hit store entries that were written or lie beyond the store.
    task automatic probe();
        logic [7:0] idx;
        logic [7:0] addr;
        if ($urandom_range(0, 1) == 0) begin
            idx = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 9));
            send_word(OP_QUERY, 8'($urandom), idx, 8'($urandom), 1'b0, '0);
        end else begin
            if (written_top > 0 && $urandom_range(0, 3) != 0)
                addr = 8'($urandom_range(0, written_top - 1));
            else
                addr = 8'($urandom_range(LINE_BYTES, 255));
            send_word(OP_READ, 8'($urandom), 8'($urandom), addr, 1'b0, '0);
        end
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT));
    endfunction

    // Stimulus: directed table first, then random lines, then drain.
    initial begin : stimulus
        step_t       plan [$];
        step_t       s;
        int unsigned first_random;
        int unsigned ntok;
        int unsigned nlen;
        int unsigned kind;
        logic [7:0]  ch;
        logic [7:0]  seps [4];
        logic [7:0]  ends [3];
        seps = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
        ends = '{CH_LF, CH_CR, CH_NUL};

        // Empty line after reset, out-of-range reads and the unused op.
        plan.push_back(row(OP_QUERY, 8'h00, 8'h00, 8'h00, 1, 1'b1, flag_result(0, 0, 1)));
        plan.push_back(row(OP_QUERY, 8'hFF, 8'hFF, 8'hFF, 1, 1'b1, flag_result(0, 0, 1)));
        plan.push_back(row(OP_READ, 8'h00, 8'h00, 8'hFF, 1, 1'b1, '0));
        plan.push_back(row(OP_READ, 8'hFF, 8'hFF, 8'd64, 1, 1'b1, '0));
        plan.push_back(row(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 1, 1'b1, '0));
        // A line with a space, a tab, a vertical tab and a form feed, ended by a newline.
        plan.push_back(row(OP_PUSH, 8'h61, 8'h00, 8'h00, 1, 1'b1, '0));
        plan.push_back(row(OP_PUSH, 8'hFF, 8'h00, 8'h00, 1, 1'b1, '0));
        plan.push_back(row(OP_PUSH, CH_SPACE, 8'h00, 8'h00, 1, 1'b1, '0));
        plan.push_back(row(OP_PUSH, 8'h62, 8'h00, 8'h00, 1, 1'b0, '0));
        plan.push_back(row(OP_PUSH, CH_TAB, 8'h00, 8'h00, 1, 1'b0, '0));
        plan.push_back(row(OP_PUSH, CH_VT, 8'h00, 8'h00, 1, 1'b0, '0));
        plan.push_back(row(OP_PUSH, CH_FF, 8'h00, 8'h00, 1, 1'b0, '0));
        plan.push_back(row(OP_PUSH, CH_LF, 8'h00, 8'h00, 1, 1'b1, flag_result(1, 0, 0)));
        // The finished line stays visible until the next push.
        plan.push_back(row(OP_QUERY, 8'h00, 8'd1, 8'h00, 1, 1'b0, '0));
        plan.push_back(row(OP_QUERY, 8'h00, 8'd5, 8'h00, 1, 1'b0, '0));
        plan.push_back(row(OP_READ, 8'h00, 8'h00, 8'd2, 1, 1'b1, '0));
        plan.push_back(row(OP_READ, 8'h00, 8'h00, 8'd1, 1, 1'b0, '0));
        // Lines too short to record an end.
        plan.push_back(row(OP_PUSH, CH_CR, 8'h00, 8'h00, 1, 1'b1, '0));
        plan.push_back(row(OP_PUSH, CH_NUL, 8'h00, 8'h00, 1, 1'b1, '0));
        plan.push_back(row(OP_QUERY, 8'h00, 8'h00, 8'h00, 1, 1'b1, flag_result(0, 0, 1)));
        // Fill the store, then overflow it.
        plan.push_back(row(OP_PUSH, 8'h78, 8'h00, 8'h00, LINE_BYTES, 1'b0, '0));
        plan.push_back(row(OP_PUSH, 8'h79, 8'h00, 8'h00, 1, 1'b1, flag_result(0, 1, 0)));
        // More token ends than the table holds.
        plan.push_back(row(OP_PUSH, CH_SPACE, 8'h00, 8'h00, 12, 1'b0, '0));
        plan.push_back(row(OP_PUSH, CH_LF, 8'h00, 8'h00, 1, 1'b1, flag_result(1, 0, 0)));
        plan.push_back(row(OP_QUERY, 8'h00, 8'd7, 8'h00, 1, 1'b0, '0));
        plan.push_back(row(OP_QUERY, 8'h00, 8'd8, 8'h00, 1, 1'b1, flag_result(0, 0, 1)));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            s = plan[i];
            repeat (s.reps)
                send_word(s.op, s.ch, s.idx, s.addr, s.typed, s.want);
        end

        // Random part: mostly well-formed lines with probes, some long lines and noise.
        first_random = words_sent;
        while (words_sent - first_random < RANDOM_WORDS) begin
            kind = $urandom_range(0, 19);
            if (kind < 16) begin
                ntok = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
                for (int t = 0; t < ntok; t++) begin
                    nlen = $urandom_range(1, 6);
                    repeat (nlen) begin
                        push_char(printable());
                        if ($urandom_range(0, 4) == 0)
                            probe();
                    end
                    if (t < ntok - 1)
                        push_char(seps[$urandom_range(0, 3)]);
                end
                push_char(ends[$urandom_range(0, 2)]);
                repeat ($urandom_range(1, ntok + 2))
                    probe();
            end else if (kind < 18) begin
                // Long line with random content, which can overflow the store.
                repeat ($urandom_range(58, 70)) begin
                    ch = 8'($urandom);
                    if (ch == CH_LF || ch == CH_CR || ch == CH_NUL)
                        ch = printable();
                    push_char(ch);
                end
                repeat ($urandom_range(0, 3))
                    probe();
            end else begin
                // Noise: raw bytes, probes and the unused op.
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0: push_char(8'($urandom));
                        1: send_word(OP_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
                                     1'b0, '0);
                        default: probe();
                    endcase
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: a changing stall pattern, plus one long hold-off to back up the input.
    initial begin : receiver
        int unsigned cyc;
        logic [15:0] pattern;
        bit          held;
        cyc = 0;
        pattern = '1;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= HOLDOFF_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
            end
            if (cyc % 48 == 0)
                pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0101);
            m_ready <= pattern[cyc % 16];
            cyc++;
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s of result word %0d: expected %0h, got %0h",
                         name, results_seen, want, got);
        end
    endtask

    // Each accepted result word is checked against the oldest prediction.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word %0d arrived with nothing expected", results_seen);
            end else begin
                want = pending_results.pop_front();
                check_field("line_done", 8'(want.line_done), 8'(m_line_done));
                check_field("input_overflow", 8'(want.input_overflow), 8'(m_input_overflow));
                check_field("token_missing", 8'(want.token_missing), 8'(m_token_missing));
                check_field("token_offset", want.token_offset, m_token_offset);
                check_field("token_length", want.token_length, m_token_length);
                check_field("byte_value", want.byte_value, m_byte_value);
            end
            results_seen++;
        end
    end

    // Hard stop if the run hangs.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
